// ----- rtl/core/taof_pkg.sv -----
// shared types and constants for the three-axis average and offset filter
// no dependencies
package taof_pkg;

    localparam int AXES     = 3;
    localparam int SAMPLE_W = 16;

    // one axis value, two's complement
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // one x/y/z triple: index 0 is x, 1 is y, 2 is z
    typedef logic [AXES-1:0][SAMPLE_W-1:0] xyz_t;

endpackage

// ----- rtl/core/three_axis_average_offset_filter.sv -----
// three-axis moving average with offset subtraction and offset calibration
// takes one sample at a time: the next only once the result is in the output register,
// which holds while a result is waiting there and result_ready is low; the averages pass
// the 3-stage constant dividers, and a sample ending a run also the offset dividers
// reset: history cells, offsets, calibration sums and count all clear to zero at once
// depends on taof_pkg, taof_cell, taof_floordiv
module three_axis_average_offset_filter #(
    parameter int WINDOW_DEPTH = 8,
    parameter int CAL_SAMPLES  = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // sample channel
    input  logic                    sample_valid,
    output logic                    sample_ready,
    input  logic                    req_type,
    input  taof_pkg::sample_t       x_sample,
    input  taof_pkg::sample_t       y_sample,
    input  taof_pkg::sample_t       z_sample,
    // result channel
    output logic                    result_valid,
    input  logic                    result_ready,
    output taof_pkg::sample_t       x_field,
    output taof_pkg::sample_t       y_field,
    output taof_pkg::sample_t       z_field,
    output logic                    calibrating,
    output logic                    offset_updated
);
    import taof_pkg::*;

    // widths that follow from the window and run lengths
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int CAL_W = SAMPLE_W + $clog2(CAL_SAMPLES);
    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a sample
    localparam logic [1:0] ST_AVG  = 2'd1;   // averages in flight
    localparam logic [1:0] ST_CAL  = 2'd2;   // new offsets in flight
    localparam logic [1:0] ST_DONE = 2'd3;   // result waits for the output register

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic sample_xfer;
    logic result_xfer;

    // history chain: newest triple in cell 0, the oldest falls out of the last cell
    xyz_t new_xyz;
    xyz_t chain [WINDOW_DEPTH];

    // running window sums, one per axis
    logic signed [SUM_W-1:0] win_sum_reg  [AXES];
    logic signed [SUM_W-1:0] win_sum_next [AXES];

    // divider results
    logic                    avg_done [AXES];
    logic signed [SUM_W-1:0] avg_q    [AXES];
    logic                    cal_done [AXES];
    logic signed [CAL_W-1:0] cal_q    [AXES];

    // calibration state
    sample_t                 offset_reg   [AXES];
    logic signed [CAL_W-1:0] cal_sum_reg  [AXES];
    logic signed [CAL_W-1:0] cal_sum_next [AXES];
    logic [CNT_W-1:0]        cal_count_reg;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    run_end;
    logic                    cal_start;

    // per-sample working registers
    logic    cal_req_reg;
    sample_t res_reg  [AXES];
    sample_t res_next [AXES];
    logic    calib_flag_reg;
    logic    upd_flag_reg;

    // output register
    logic    out_valid_reg;
    sample_t out_field_reg [AXES];
    logic    out_calib_reg;
    logic    out_upd_reg;

    assign sample_ready = (state_reg == ST_IDLE);
    assign sample_xfer  = sample_valid && sample_ready;
    assign result_xfer  = out_valid_reg && result_ready;

    assign new_xyz[0] = x_sample;
    assign new_xyz[1] = y_sample;
    assign new_xyz[2] = z_sample;

    // row of history cells, all shift on a sample transfer
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                taof_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (sample_xfer),
                    .din   (new_xyz),
                    .dout  (chain[gi])
                );
            end
            else
            begin : g_body
                taof_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (sample_xfer),
                    .din   (chain[gi-1]),
                    .dout  (chain[gi])
                );
            end
        end
    endgenerate

    // window sum: add the incoming value, drop the one leaving the last cell
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            win_sum_next[a] = win_sum_reg[a]
                            + SUM_W'($signed(new_xyz[a]))
                            - SUM_W'($signed(chain[WINDOW_DEPTH-1][a]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                win_sum_reg[a] <= '0;
            end
        end
        else if (sample_xfer)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                win_sum_reg[a] <= win_sum_next[a];
            end
        end
    end

    // average: floor of the window sum over the depth, started on the fresh sum
    // offset: floor of the calibration sum over the run length
    generate
        for (gi = 0; gi < AXES; gi++)
        begin : g_axis
            taof_floordiv #(
                .IN_W    (SUM_W),
                .DIVISOR (WINDOW_DEPTH)
            ) u_avg_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .start    (sample_xfer),
                .dividend (win_sum_next[gi]),
                .done     (avg_done[gi]),
                .quotient (avg_q[gi])
            );

            taof_floordiv #(
                .IN_W    (CAL_W),
                .DIVISOR (CAL_SAMPLES)
            ) u_cal_div (
                .clk      (clk),
                .rst_n    (rst_n),
                .start    (cal_start),
                .dividend (cal_sum_next[gi]),
                .done     (cal_done[gi]),
                .quotient (cal_q[gi])
            );
        end
    endgenerate

    // filtered result and calibration bookkeeping
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            // difference wraps to 16 bits
            res_next[a]     = avg_q[a][SAMPLE_W-1:0] - offset_reg[a];
            cal_sum_next[a] = cal_sum_reg[a] + CAL_W'(res_next[a]);
        end
        cnt_inc   = cal_count_reg + 1'b1;
        run_end   = cal_req_reg && (cnt_inc == CNT_W'(CAL_SAMPLES));
        cal_start = (state_reg == ST_AVG) && avg_done[0] && run_end;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:
            begin
                if (avg_done[0])
                begin
                    state_next = run_end ? ST_CAL : ST_DONE;
                end
            end
            ST_CAL:
            begin
                if (cal_done[0])
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cal_count_reg <= '0;
            for (int a = 0; a < AXES; a++)
            begin
                offset_reg[a]  <= '0;
                cal_sum_reg[a] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            // a calibration sample adds its results; the last one of a run clears the sums
            if ((state_reg == ST_AVG) && avg_done[0] && cal_req_reg)
            begin
                cal_count_reg <= run_end ? '0 : cnt_inc;
                for (int a = 0; a < AXES; a++)
                begin
                    cal_sum_reg[a] <= run_end ? '0 : cal_sum_next[a];
                end
            end
            // new offsets take effect from the next sample on
            if ((state_reg == ST_CAL) && cal_done[0])
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    offset_reg[a] <= cal_q[a][SAMPLE_W-1:0];
                end
            end
        end
    end

    // working registers for the sample in flight
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            cal_req_reg <= req_type;
        end
        if ((state_reg == ST_AVG) && avg_done[0])
        begin
            for (int a = 0; a < AXES; a++)
            begin
                res_reg[a] <= res_next[a];
            end
            calib_flag_reg <= cal_req_reg ? !run_end : (cal_count_reg != '0);
            upd_flag_reg   <= run_end;
        end
    end

    // output register: takes the result as soon as the previous one is gone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && (!out_valid_reg || result_ready))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && (!out_valid_reg || result_ready))
        begin
            for (int a = 0; a < AXES; a++)
            begin
                out_field_reg[a] <= res_reg[a];
            end
            out_calib_reg <= calib_flag_reg;
            out_upd_reg   <= upd_flag_reg;
        end
    end

    assign result_valid   = out_valid_reg;
    assign x_field        = out_field_reg[0];
    assign y_field        = out_field_reg[1];
    assign z_field        = out_field_reg[2];
    assign calibrating    = out_calib_reg;
    assign offset_updated = out_upd_reg;

endmodule

// ----- rtl/core/taof_cell.sv -----
// one history cell: holds an x/y/z triple and passes it to the next cell on a shift
// depends on taof_pkg
module taof_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  taof_pkg::xyz_t din,
    output taof_pkg::xyz_t dout
);
    import taof_pkg::*;

    xyz_t data_reg;
    xyz_t data_next;

    always_comb
    begin
        data_next = shift ? din : data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

// ----- rtl/core/taof_floordiv.sv -----
// three-stage floor division of a signed value by a constant divisor
// reciprocal multiply with one correction step; depends on nothing
module taof_floordiv #(
    parameter int IN_W    = 19,
    parameter int DIVISOR = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [IN_W-1:0] dividend,
    output logic                   done,
    output logic signed [IN_W-1:0] quotient
);
    localparam int SHIFT  = IN_W + $clog2(DIVISOR);
    localparam int PROD_W = IN_W + SHIFT;
    localparam logic [SHIFT-1:0] RECIP = SHIFT'((65'd1 << SHIFT) / DIVISOR);
    localparam logic [IN_W-1:0]  DIV_C = IN_W'(DIVISOR);
    localparam logic [IN_W-1:0]  DIV_M1 = IN_W'(DIVISOR - 1);

    // stage 1: magnitude, biased for rounding toward minus infinity
    logic              s1_valid_reg;
    logic              s1_neg_reg;
    logic [IN_W-1:0]   s1_mag_reg;
    logic [IN_W-1:0]   s1_mag_next;

    // stage 2: estimate from the reciprocal, low by at most one
    logic              s2_valid_reg;
    logic              s2_neg_reg;
    logic [IN_W-1:0]   s2_mag_reg;
    logic [IN_W-1:0]   s2_q0_reg;
    logic [PROD_W-1:0] prod;

    // stage 3: correction and sign
    logic              s3_valid_reg;
    logic [IN_W-1:0]   s3_q_reg;
    logic [IN_W-1:0]   rem;
    logic [IN_W-1:0]   q_fix;
    logic [IN_W-1:0]   q_next;

    always_comb
    begin
        if (dividend[IN_W-1])
        begin
            s1_mag_next = (~dividend + 1'b1) + DIV_M1;
        end
        else
        begin
            s1_mag_next = dividend;
        end
        prod   = PROD_W'(s1_mag_reg) * PROD_W'(RECIP);
        rem    = s2_mag_reg - s2_q0_reg * DIV_C;
        q_fix  = s2_q0_reg + IN_W'(rem >= DIV_C);
        q_next = s2_neg_reg ? (~q_fix + 1'b1) : q_fix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_neg_reg <= dividend[IN_W-1];
        s1_mag_reg <= s1_mag_next;
        s2_neg_reg <= s1_neg_reg;
        s2_mag_reg <= s1_mag_reg;
        s2_q0_reg  <= prod[PROD_W-1:SHIFT];
        s3_q_reg   <= q_next;
    end

    assign done     = s3_valid_reg;
    assign quotient = $signed(s3_q_reg);

endmodule
